// ----- rtl/rotation_curve_force_assert.svh -----
// Assertion macros used by the rotation curve force top level.
`ifndef ROTATION_CURVE_FORCE_ASSERT_SVH
`define ROTATION_CURVE_FORCE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rcf_pkg.sv -----
// Shared constants, types and helper functions of the rotation curve force block.
`timescale 1ns / 1ps
package rcf_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int ROOT_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int SQ_LAT  = ROOT_W + 1;
    localparam int DIV_LAT = ROOT_W + 1;

    localparam logic signed [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [63:0] DMAX64 = 64'(DMAX);
    localparam logic signed [63:0] DMIN64 = 64'(DMIN);

    typedef enum logic [2:0] {
        REG_INNER_RADIUS,
        REG_OUTER_RADIUS,
        REG_OUTER_SPEED,
        REG_SPEED_GRADIENT,
        REG_VERTICAL_STRENGTH,
        REG_SCALE_HEIGHT
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_xy;

    typedef struct packed {
        logic                     inner;
        logic                     neg;
        logic signed [DATA_W-1:0] vout;
        logic [ROOT_W-1:0]        r;
        t_xy                      xy;
    } t_dv_sb;

    typedef struct packed {
        logic neg;
        logic dzero;
    } t_dz_sb;

    typedef struct packed {
        logic                     rzero;
        t_xy                      xy;
        logic signed [DATA_W-1:0] accz;
    } t_dw_sb;

    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > DMAX64) begin
            res = DMAX;
        end else if (v < DMIN64) begin
            res = DMIN;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [63:0] apply_sign(input logic neg,
                                                      input logic [ROOT_W-1:0] q);
        logic signed [63:0] m;
        m = signed'({{(64-ROOT_W){1'b0}}, q});
        return neg ? -m : m;
    endfunction

endpackage

// ----- rtl/rcf_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rcf_sqrt #(
    parameter int SB_W = 2 * rcf_pkg::DATA_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [63:0]               i_rad,
    input  logic [SB_W-1:0]           i_sb,
    output logic                      o_vld,
    output logic [rcf_pkg::ROOT_W-1:0] o_root,
    output logic [SB_W-1:0]           o_sb
);
    import rcf_pkg::*;

    localparam int N = ROOT_W;

    logic [N:0]        r_vld;
    logic [33:0]       r_rem  [0:N];
    logic [N-1:0]      r_root [0:N];
    logic [63:0]       r_rad  [0:N];
    logic [SB_W-1:0]   r_sb   [0:N];
    logic [35:0]       w_t    [1:N];
    logic [35:0]       w_trial[1:N];
    logic [35:0]       w_diff [1:N];
    logic [33:0]       n_rem  [1:N];
    logic [N-1:0]      n_root [1:N];

    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_t[k+1]     = {r_rem[k], r_rad[k][63:62]};
            w_trial[k+1] = {2'b00, r_root[k], 2'b01};
            w_diff[k+1]  = w_t[k+1] - w_trial[k+1];
            if (w_t[k+1] >= w_trial[k+1]) begin
                n_rem[k+1]  = w_diff[k+1][33:0];
                n_root[k+1] = {r_root[k][N-2:0], 1'b1};
            end else begin
                n_rem[k+1]  = w_t[k+1][33:0];
                n_root[k+1] = {r_root[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_rad[0]  <= i_rad;
        r_sb[0]   <= i_sb;
        for (int k = 0; k < N; k++) begin
            r_rem[k+1]  <= n_rem[k+1];
            r_root[k+1] <= n_root[k+1];
            r_rad[k+1]  <= {r_rad[k][61:0], 2'b00};
            r_sb[k+1]   <= r_sb[k];
        end
    end

    assign o_vld  = r_vld[N];
    assign o_root = r_root[N];
    assign o_sb   = r_sb[N];

endmodule

// ----- rtl/rcf_div.sv -----
// Pipelined restoring divider of a 64-bit dividend by a 32-bit divisor with overflow flag.
`timescale 1ns / 1ps
module rcf_div #(
    parameter int SB_W = 2 * rcf_pkg::DATA_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [63:0]                i_num,
    input  logic [rcf_pkg::ROOT_W-1:0] i_den,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_vld,
    output logic [rcf_pkg::ROOT_W-1:0] o_quo,
    output logic                       o_ovf,
    output logic [SB_W-1:0]            o_sb
);
    import rcf_pkg::*;

    localparam int N = ROOT_W;

    logic [N:0]      r_vld;
    logic [N-1:0]    r_rem [0:N];
    logic [N-1:0]    r_lo  [0:N];
    logic [N-1:0]    r_den [0:N];
    logic [N:0]      r_ovf;
    logic [SB_W-1:0] r_sb  [0:N];
    logic [N:0]      w_t   [1:N];
    logic [N:0]      w_diff[1:N];
    logic            w_ge  [1:N];
    logic [N-1:0]    n_rem [1:N];

    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_t[k+1]    = {r_rem[k], r_lo[k][N-1]};
            w_diff[k+1] = w_t[k+1] - {1'b0, r_den[k]};
            w_ge[k+1]   = w_t[k+1] >= {1'b0, r_den[k]};
            n_rem[k+1]  = w_ge[k+1] ? w_diff[k+1][N-1:0] : w_t[k+1][N-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num[63:32];
        r_lo[0]  <= i_num[31:0];
        r_den[0] <= i_den;
        r_ovf[0] <= i_num[63:32] >= i_den;
        r_sb[0]  <= i_sb;
        for (int k = 0; k < N; k++) begin
            r_rem[k+1] <= n_rem[k+1];
            r_lo[k+1]  <= {r_lo[k][N-2:0], w_ge[k+1]};
            r_den[k+1] <= r_den[k];
            r_ovf[k+1] <= r_ovf[k];
            r_sb[k+1]  <= r_sb[k];
        end
    end

    assign o_vld = r_vld[N];
    assign o_quo = r_lo[N];
    assign o_ovf = r_ovf[N];
    assign o_sb  = r_sb[N];

endmodule

// ----- rtl/rotation_curve_force.sv -----
// Top level of the rotation curve force pipeline with its register port.
// The block takes one position item per clock cycle and never raises busy. Each item
// leaves as one result, marked by o_valid for one cycle, and results come out in the
// order the items went in. Each item passes through the 33-stage square root and then
// two 33-stage dividers in sequence, each stage after the first resolving one result
// bit. Registers are written through the APB port; write them only while no item
// is in flight.
`timescale 1ns / 1ps
`include "rotation_curve_force_assert.svh"
module rotation_curve_force (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rcf_pkg::DATA_W-1:0] i_pos_x,
    input  logic signed [rcf_pkg::DATA_W-1:0] i_pos_y,
    input  logic signed [rcf_pkg::DATA_W-1:0] i_pos_z,
    output logic                              o_valid,
    output logic signed [rcf_pkg::DATA_W-1:0] o_acc_x,
    output logic signed [rcf_pkg::DATA_W-1:0] o_acc_y,
    output logic signed [rcf_pkg::DATA_W-1:0] o_acc_z,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcf_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import rcf_pkg::*;

    localparam int LATENCY = 4 + SQ_LAT + 3 + DIV_LAT + 2 + DIV_LAT + 5;

    logic [30:0]        r_inner;
    logic [30:0]        r_outer;
    logic signed [31:0] r_v1;
    logic signed [31:0] r_dvdr;
    logic signed [31:0] r_vstr;
    logic [30:0]        r_height;
    logic signed [63:0] r_v0_prod;
    logic signed [31:0] r_v0;
    t_reg_idx           w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner  <= 31'd66;
            r_outer  <= 31'd65536;
            r_v1     <= 32'sd65536;
            r_dvdr   <= 32'sd0;
            r_vstr   <= 32'sd65536;
            r_height <= 31'd13107;
        end else if (w_wr) begin
            case (w_idx)
                REG_INNER_RADIUS:      r_inner  <= pwdata[30:0];
                REG_OUTER_RADIUS:      r_outer  <= pwdata[30:0];
                REG_OUTER_SPEED:       r_v1     <= signed'(pwdata);
                REG_SPEED_GRADIENT:    r_dvdr   <= signed'(pwdata);
                REG_VERTICAL_STRENGTH: r_vstr   <= signed'(pwdata);
                REG_SCALE_HEIGHT:      r_height <= pwdata[30:0];
                default:               ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_INNER_RADIUS:      prdata = {1'b0, r_inner};
            REG_OUTER_RADIUS:      prdata = {1'b0, r_outer};
            REG_OUTER_SPEED:       prdata = r_v1;
            REG_SPEED_GRADIENT:    prdata = r_dvdr;
            REG_VERTICAL_STRENGTH: prdata = r_vstr;
            REG_SCALE_HEIGHT:      prdata = {1'b0, r_height};
            default:               prdata = '0;
        endcase
    end

    // The speed at the inner radius depends on the registers alone.
    always_ff @(posedge i_clk) begin
        r_v0_prod <= (signed'({1'b0, r_outer}) - signed'({1'b0, r_inner})) * r_dvdr;
        r_v0      <= sat64(64'(r_v1) - (r_v0_prod >>> FRAC_W));
    end

    logic               r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic signed [31:0] r_s1_x, r_s1_y, r_s1_z;
    logic [31:0]        r_s2_ax, r_s2_ay, r_s2_az;
    logic signed [31:0] r_s2_x, r_s2_y, r_s2_z;
    logic [63:0]        r_s3_xx, r_s3_yy, r_s3_zz;
    logic [61:0]        r_s3_hh;
    logic signed [31:0] r_s3_x, r_s3_y, r_s3_z;
    logic [63:0]        r_s4_rr, r_s4_dd;
    t_xy                r_s4_xy;
    logic signed [31:0] r_s4_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x  <= i_pos_x;
        r_s1_y  <= i_pos_y;
        r_s1_z  <= i_pos_z;
        r_s2_ax <= r_s1_x[31] ? 32'(-r_s1_x) : 32'(r_s1_x);
        r_s2_ay <= r_s1_y[31] ? 32'(-r_s1_y) : 32'(r_s1_y);
        r_s2_az <= r_s1_z[31] ? 32'(-r_s1_z) : 32'(r_s1_z);
        r_s2_x  <= r_s1_x;
        r_s2_y  <= r_s1_y;
        r_s2_z  <= r_s1_z;
        r_s3_xx <= 64'(r_s2_ax) * 64'(r_s2_ax);
        r_s3_yy <= 64'(r_s2_ay) * 64'(r_s2_ay);
        r_s3_zz <= 64'(r_s2_az) * 64'(r_s2_az);
        r_s3_hh <= 62'(r_height) * 62'(r_height);
        r_s3_x  <= r_s2_x;
        r_s3_y  <= r_s2_y;
        r_s3_z  <= r_s2_z;
        r_s4_rr <= r_s3_xx + r_s3_yy;
        r_s4_dd <= r_s3_zz + 64'(r_s3_hh);
        r_s4_xy <= '{x: r_s3_x, y: r_s3_y};
        r_s4_z  <= r_s3_z;
    end

    logic               w_sqr_vld, w_sqd_vld;
    logic [31:0]        w_sqr_root, w_sqd_root;
    t_xy                w_sqr_sb;
    logic [31:0]        w_sqd_sb;

    rcf_sqrt #(.SB_W($bits(t_xy))) u_sqrt_r (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s4_vld),
        .i_rad  (r_s4_rr),
        .i_sb   (r_s4_xy),
        .o_vld  (w_sqr_vld),
        .o_root (w_sqr_root),
        .o_sb   (w_sqr_sb)
    );

    rcf_sqrt #(.SB_W(DATA_W)) u_sqrt_d (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s4_vld),
        .i_rad  (r_s4_dd),
        .i_sb   (r_s4_z),
        .o_vld  (w_sqd_vld),
        .o_root (w_sqd_root),
        .o_sb   (w_sqd_sb)
    );

    logic               r_s5_vld, r_s6_vld, r_s7_vld;
    logic               r_s5_inner, r_s6_inner, r_s7_inner;
    logic [31:0]        r_s5_ma, r_s5_r, r_s5_d, r_s6_r, r_s6_d, r_s7_r, r_s7_d;
    t_xy                r_s5_xy, r_s6_xy, r_s7_xy;
    logic signed [31:0] r_s5_z;
    logic signed [64:0] r_s6_prod;
    logic signed [63:0] r_s6_zp;
    logic [63:0]        r_s7_num, r_s7_znum;
    logic               r_s7_neg, r_s7_zneg;
    logic signed [31:0] r_s7_vout;
    logic               w_inner;
    logic signed [31:0] w_mb;
    logic signed [64:0] w_sh, w_pabs;
    logic signed [63:0] w_vsum, w_zabs;

    assign w_inner = w_sqr_root < {1'b0, r_inner};
    assign w_mb    = r_s5_inner ? r_v0 : r_dvdr;
    assign w_sh    = r_s6_prod >>> FRAC_W;
    assign w_vsum  = 64'(r_v0) + signed'(w_sh[63:0]);
    assign w_pabs  = r_s6_prod[64] ? -r_s6_prod : r_s6_prod;
    assign w_zabs  = r_s6_zp[63] ? -r_s6_zp : r_s6_zp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else begin
            r_s5_vld <= w_sqr_vld;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_inner <= w_inner;
        r_s5_ma    <= w_inner ? w_sqr_root : w_sqr_root - {1'b0, r_inner};
        r_s5_r     <= w_sqr_root;
        r_s5_d     <= w_sqd_root;
        r_s5_xy    <= w_sqr_sb;
        r_s5_z     <= signed'(w_sqd_sb);
        r_s6_prod  <= signed'({1'b0, r_s5_ma}) * w_mb;
        r_s6_zp    <= r_vstr * r_s5_z;
        r_s6_inner <= r_s5_inner;
        r_s6_r     <= r_s5_r;
        r_s6_d     <= r_s5_d;
        r_s6_xy    <= r_s5_xy;
        r_s7_num   <= w_pabs[63:0];
        r_s7_neg   <= r_s6_prod[64];
        r_s7_vout  <= sat64(w_vsum);
        r_s7_inner <= r_s6_inner;
        r_s7_znum  <= w_zabs;
        r_s7_zneg  <= r_s6_zp[63];
        r_s7_r     <= r_s6_r;
        r_s7_d     <= r_s6_d;
        r_s7_xy    <= r_s6_xy;
    end

    logic               w_dv_vld, w_dz_vld, w_dv_ovf, w_dz_ovf;
    logic [31:0]        w_dv_quo, w_dz_quo;
    t_dv_sb             w_dv_sb;
    t_dz_sb             w_dz_sb;

    rcf_div #(.SB_W($bits(t_dv_sb))) u_div_v (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s7_vld),
        .i_num  (r_s7_num),
        .i_den  ({1'b0, r_inner}),
        .i_sb   (t_dv_sb'{inner: r_s7_inner, neg: r_s7_neg, vout: r_s7_vout,
                          r: r_s7_r, xy: r_s7_xy}),
        .o_vld  (w_dv_vld),
        .o_quo  (w_dv_quo),
        .o_ovf  (w_dv_ovf),
        .o_sb   (w_dv_sb)
    );

    rcf_div #(.SB_W($bits(t_dz_sb))) u_div_z (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s7_vld),
        .i_num  (r_s7_znum),
        .i_den  (r_s7_d),
        .i_sb   (t_dz_sb'{neg: r_s7_zneg, dzero: r_s7_d == '0}),
        .o_vld  (w_dz_vld),
        .o_quo  (w_dz_quo),
        .o_ovf  (w_dz_ovf),
        .o_sb   (w_dz_sb)
    );

    logic               r_s8_vld, r_s9_vld;
    logic signed [31:0] r_s8_v;
    logic [31:0]        r_s8_r;
    t_xy                r_s8_xy, r_s9_xy;
    logic signed [31:0] r_s8_accz, r_s9_accz, w_accz;
    logic [63:0]        r_s9_num;
    logic [31:0]        r_s9_r, w_av;
    logic               r_s9_rzero;

    always_comb begin
        if (w_dz_sb.dzero) begin
            w_accz = '0;
        end else if (w_dz_ovf) begin
            w_accz = w_dz_sb.neg ? DMAX : DMIN;
        end else begin
            w_accz = sat64(apply_sign(!w_dz_sb.neg, w_dz_quo));
        end
    end

    assign w_av = r_s8_v[31] ? 32'(-r_s8_v) : 32'(r_s8_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
            r_s9_vld <= 1'b0;
        end else begin
            r_s8_vld <= w_dv_vld;
            r_s9_vld <= r_s8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s8_v     <= w_dv_sb.inner ? sat64(apply_sign(w_dv_sb.neg, w_dv_quo)) : w_dv_sb.vout;
        r_s8_r     <= w_dv_sb.r;
        r_s8_xy    <= w_dv_sb.xy;
        r_s8_accz  <= w_accz;
        r_s9_num   <= {{(64-32-FRAC_W){1'b0}}, w_av, {FRAC_W{1'b0}}};
        r_s9_r     <= r_s8_r;
        r_s9_rzero <= r_s8_r == '0;
        r_s9_xy    <= r_s8_xy;
        r_s9_accz  <= r_s8_accz;
    end

    logic               w_dw_vld, w_dw_ovf;
    logic [31:0]        w_dw_quo;
    t_dw_sb             w_dw_sb;

    rcf_div #(.SB_W($bits(t_dw_sb))) u_div_w (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s9_vld),
        .i_num  (r_s9_num),
        .i_den  (r_s9_r),
        .i_sb   (t_dw_sb'{rzero: r_s9_rzero, xy: r_s9_xy, accz: r_s9_accz}),
        .o_vld  (w_dw_vld),
        .o_quo  (w_dw_quo),
        .o_ovf  (w_dw_ovf),
        .o_sb   (w_dw_sb)
    );

    logic               r_s10_vld, r_s11_vld, r_s12_vld, r_s13_vld;
    logic [30:0]        r_s10_w, r_s12_f;
    logic [61:0]        r_s11_ww;
    logic               r_s10_rzero, r_s11_rzero;
    t_xy                r_s10_xy, r_s11_xy, r_s12_xy;
    logic signed [31:0] r_s10_accz, r_s11_accz, r_s12_accz, r_s13_accz;
    logic signed [63:0] r_s13_px, r_s13_py;
    logic [45:0]        w_fhi;

    assign w_fhi = r_s11_ww[61:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_s13_vld <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_s10_vld <= w_dw_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_s13_vld <= r_s12_vld;
            o_valid   <= r_s13_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s10_w     <= (w_dw_ovf || w_dw_quo[31]) ? DMAX[30:0] : w_dw_quo[30:0];
        r_s10_rzero <= w_dw_sb.rzero;
        r_s10_xy    <= w_dw_sb.xy;
        r_s10_accz  <= w_dw_sb.accz;
        r_s11_ww    <= 62'(r_s10_w) * 62'(r_s10_w);
        r_s11_rzero <= r_s10_rzero;
        r_s11_xy    <= r_s10_xy;
        r_s11_accz  <= r_s10_accz;
        if (r_s11_rzero) begin
            r_s12_f <= '0;
        end else if (|w_fhi[45:31]) begin
            r_s12_f <= DMAX[30:0];
        end else begin
            r_s12_f <= w_fhi[30:0];
        end
        r_s12_xy    <= r_s11_xy;
        r_s12_accz  <= r_s11_accz;
        r_s13_px    <= signed'({1'b0, r_s12_f}) * r_s12_xy.x;
        r_s13_py    <= signed'({1'b0, r_s12_f}) * r_s12_xy.y;
        r_s13_accz  <= r_s12_accz;
        o_acc_x     <= sat64(-(r_s13_px >>> FRAC_W));
        o_acc_y     <= sat64(-(r_s13_py >>> FRAC_W));
        o_acc_z     <= r_s13_accz;
    end

    `RCF_ASSERT_NOW(a_sqrt_lanes, i_clk, i_rst_n, 1'b1, w_sqr_vld == w_sqd_vld, "square root lanes out of step")
    `RCF_ASSERT_NOW(a_div_lanes, i_clk, i_rst_n, 1'b1, w_dv_vld == w_dz_vld, "divider lanes out of step")
    `RCF_ASSERT_NOW(a_latency, i_clk, i_rst_n, o_valid, $past(start, LATENCY), "result without a matching item")
    `RCF_ASSERT_NEXT(a_no_busy, i_clk, i_rst_n, start, !busy, "busy raised")

endmodule
